// File: hdl/stub_pkg.sv
package stub_pkg;

   localparam int NUM_LEGS_DEF   = 6;
   localparam int JOINTS_DEF     = 3;

   localparam int LEG_W      = 3;
   localparam int JOINT_W    = 2;
   localparam int ANGLE_W    = 11;
   localparam int DUR_W      = 15;
   localparam int SCALE_W    = 16;
   localparam int CODE_W     = 10;
   localparam int ID_W       = 5;
   localparam int CNT_W      = 5;
   localparam int MAG_W      = 11;
   localparam int PROD_W     = SCALE_W + MAG_W;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CODE_W-1:0]    CODE_MAX    = 10'd1023;
   localparam logic [CODE_W-1:0]    CODE_MIN    = 10'd1;
   localparam logic [CODE_W-1:0]    ZERO_RESET  = 10'd512;
   localparam logic [SCALE_W-1:0]   SCALE_RESET = 16'd1;
   localparam logic [LEG_W-1:0]     NEG_LEG_FIRST = 3'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_ZERO_POS    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_SCALE = 2'd1;

   localparam logic MODE_SET   = 1'b0;
   localparam logic MODE_FLUSH = 1'b1;

   typedef struct packed {
      logic               start;
      logic [SCALE_W-1:0] scale;
      logic [MAG_W-1:0]   mag;
      logic [DUR_W-1:0]   dur;
   } speed_req_type;

   typedef struct packed {
      logic              done;
      logic [CODE_W-1:0] speed;
   } speed_rsp_type;

endpackage

// File: hdl/stub_speed.sv
module stub_speed (
   input  logic                   clock,
   input  logic                   reset,
   input  stub_pkg::speed_req_type req,
   output stub_pkg::speed_rsp_type rsp
);
   import stub_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_MUL, S_CHK, S_DIV} state_type;

   state_type          state_ff;
   logic [PROD_W-1:0]  acc_ff;
   logic [MAG_W-1:0]   mag_ff;
   logic [SCALE_W-1:0] scale_ff;
   logic [DUR_W-1:0]   dur_ff;
   logic [DUR_W-1:0]   rem_ff;
   logic [CODE_W-1:0]  quo_ff;
   logic [3:0]         cnt_ff;
   logic               done_ff;
   logic [CODE_W-1:0]  speed_ff;

   logic [PROD_W-1:0]  acc_in;
   logic [DUR_W:0]     trial;
   logic               ge;
   logic [DUR_W:0]     diff;
   logic [CODE_W-1:0]  quo_in;
   logic               over;

   always_comb begin
      acc_in = {acc_ff[PROD_W-2:0], 1'b0}
               + (mag_ff[MAG_W-1] ? PROD_W'(scale_ff) : PROD_W'(0));
      trial  = {rem_ff, acc_ff[CODE_W-1]};
      ge     = (trial >= {1'b0, dur_ff});
      diff   = trial - {1'b0, dur_ff};
      quo_in = {quo_ff[CODE_W-2:0], ge};
      over   = (acc_ff >= PROD_W'({dur_ff, {CODE_W{1'b0}}}));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (req.start) begin
                  if (req.dur == '0) begin
                     speed_ff <= CODE_MAX;
                     done_ff  <= 1'b1;
                  end else begin
                     acc_ff   <= '0;
                     mag_ff   <= req.mag;
                     scale_ff <= req.scale;
                     dur_ff   <= req.dur;
                     cnt_ff   <= 4'(MAG_W - 1);
                     state_ff <= S_MUL;
                  end
               end
            end
            S_MUL: begin
               acc_ff <= acc_in;
               mag_ff <= {mag_ff[MAG_W-2:0], 1'b0};
               if (cnt_ff == '0) begin
                  state_ff <= S_CHK;
               end else begin
                  cnt_ff <= cnt_ff - 4'd1;
               end
            end
            S_CHK: begin
               if (over) begin
                  speed_ff <= CODE_MAX;
                  done_ff  <= 1'b1;
                  state_ff <= S_IDLE;
               end else begin
                  rem_ff   <= acc_ff[CODE_W +: DUR_W];
                  quo_ff   <= '0;
                  cnt_ff   <= 4'(CODE_W - 1);
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               rem_ff <= ge ? diff[DUR_W-1:0] : trial[DUR_W-1:0];
               quo_ff <= quo_in;
               acc_ff <= {acc_ff[PROD_W-2:0], 1'b0};
               if (cnt_ff == '0) begin
                  speed_ff <= (quo_in == '0) ? CODE_MIN : quo_in;
                  done_ff  <= 1'b1;
                  state_ff <= S_IDLE;
               end else begin
                  cnt_ff <= cnt_ff - 4'd1;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp.done  = done_ff;
   assign rsp.speed = speed_ff;

endmodule

// File: hdl/servo_target_update_batcher.sv
// set item: accepted while idle, no result, busy stays low
// flush item: scans every joint, computing a speed for each changed joint (maximum at zero
//   duration, no divide on saturation): 11-step multiply, 10-step restoring divide
// results leave one per strobe, the last one from the finish state once the scan ends
// synchronous active-high reset: targets, durations and sent angles all zero,
//   zero position 512, speed scale 1; the receiver cannot stall results
module servo_target_update_batcher #(
   parameter int NUM_LEGS       = stub_pkg::NUM_LEGS_DEF,
   parameter int JOINTS_PER_LEG = stub_pkg::JOINTS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic                             req_mode,
   input  logic [stub_pkg::LEG_W-1:0]       req_leg,
   input  logic [stub_pkg::JOINT_W-1:0]     req_joint,
   input  logic signed [stub_pkg::ANGLE_W-1:0] req_angle,
   input  logic [stub_pkg::DUR_W-1:0]       req_duration,
   output logic                             rsp_valid,
   output logic                             rsp_has_entry,
   output logic [stub_pkg::ID_W-1:0]        rsp_servo_id,
   output logic [stub_pkg::CODE_W-1:0]      rsp_position,
   output logic [stub_pkg::CODE_W-1:0]      rsp_speed,
   output logic [stub_pkg::CNT_W-1:0]       rsp_count,
   output logic                             rsp_last,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [stub_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [stub_pkg::CSR_DATA_W-1:0]  csr_data
);
   import stub_pkg::*;

   localparam int NUM_JOINTS = NUM_LEGS * JOINTS_PER_LEG;
   localparam int IDX_W      = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;

   typedef enum logic [1:0] {S_IDLE, S_CHECK, S_WAIT, S_FINISH} state_type;

   state_type           state_ff;
   logic [CODE_W-1:0]   zero_ff;
   logic [SCALE_W-1:0]  scale_ff;
   logic [ANGLE_W-1:0]  tgt_ff  [NUM_JOINTS];
   logic [DUR_W-1:0]    dur_ff  [NUM_JOINTS];
   logic [ANGLE_W-1:0]  sent_ff [NUM_JOINTS];

   logic [LEG_W-1:0]    leg_ff;
   logic [JOINT_W-1:0]  jnt_ff;
   logic [IDX_W-1:0]    idx_ff;
   logic [CNT_W-1:0]    count_ff;
   logic [CODE_W-1:0]   pos_ff;

   logic                pend_vld_ff;
   logic [ID_W-1:0]     pend_id_ff;
   logic [CODE_W-1:0]   pend_pos_ff;
   logic [CODE_W-1:0]   pend_spd_ff;
   logic [CNT_W-1:0]    pend_cnt_ff;

   logic                rsp_valid_ff;
   logic                rsp_has_entry_ff;
   logic [ID_W-1:0]     rsp_servo_id_ff;
   logic [CODE_W-1:0]   rsp_position_ff;
   logic [CODE_W-1:0]   rsp_speed_ff;
   logic [CNT_W-1:0]    rsp_count_ff;
   logic                rsp_last_ff;

   speed_req_type       spd_req_ff;
   speed_rsp_type       spd_rsp;

   logic                accept;
   logic                set_ok;
   logic [IDX_W-1:0]    set_idx;
   logic [ANGLE_W-1:0]  cur_tgt;
   logic [ANGLE_W-1:0]  cur_sent;
   logic                changed;
   logic signed [ANGLE_W+1:0] tgt_x;
   logic signed [ANGLE_W+1:0] pos_x;
   logic signed [ANGLE_W:0]   diff_x;
   logic signed [ANGLE_W:0]   abs_x;
   logic [CODE_W-1:0]   pos_clamp;
   logic                scan_end;
   logic [LEG_W-1:0]    leg_in;
   logic [JOINT_W-1:0]  jnt_in;

   stub_speed u_speed (
      .clock (clock),
      .reset (reset),
      .req   (spd_req_ff),
      .rsp   (spd_rsp)
   );

   always_comb begin
      accept  = start && !busy;
      set_ok  = ({1'b0, req_leg} < (LEG_W + 1)'(NUM_LEGS))
                && ({1'b0, req_joint} < (JOINT_W + 1)'(JOINTS_PER_LEG));
      set_idx = IDX_W'(int'(req_leg) * JOINTS_PER_LEG + int'(req_joint));
      cur_tgt  = tgt_ff[idx_ff];
      cur_sent = sent_ff[idx_ff];
      changed  = (cur_tgt != cur_sent);
      tgt_x  = {{2{cur_tgt[ANGLE_W-1]}}, cur_tgt};
      pos_x  = $signed({3'b000, zero_ff})
               + ((leg_ff >= NEG_LEG_FIRST) ? -tgt_x : tgt_x);
      if (pos_x < 0) begin
         pos_clamp = '0;
      end else if (pos_x > $signed({3'b000, CODE_MAX})) begin
         pos_clamp = CODE_MAX;
      end else begin
         pos_clamp = pos_x[CODE_W-1:0];
      end
      diff_x = $signed({cur_sent[ANGLE_W-1], cur_sent})
               - $signed({cur_tgt[ANGLE_W-1], cur_tgt});
      abs_x  = (diff_x < 0) ? -diff_x : diff_x;
      scan_end = (leg_ff == LEG_W'(NUM_LEGS - 1))
                 && (jnt_ff == JOINT_W'(JOINTS_PER_LEG - 1));
      if (jnt_ff == JOINT_W'(JOINTS_PER_LEG - 1)) begin
         jnt_in = '0;
         leg_in = leg_ff + LEG_W'(1);
      end else begin
         jnt_in = jnt_ff + JOINT_W'(1);
         leg_in = leg_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         zero_ff  <= ZERO_RESET;
         scale_ff <= SCALE_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ZERO_POS:    zero_ff  <= csr_data[CODE_W-1:0];
            CSR_SPEED_SCALE: scale_ff <= csr_data[SCALE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         rsp_valid_ff     <= 1'b0;
         pend_vld_ff      <= 1'b0;
         spd_req_ff.start <= 1'b0;
         for (int i = 0; i < NUM_JOINTS; i++) begin
            tgt_ff[i]  <= '0;
            dur_ff[i]  <= '0;
            sent_ff[i] <= '0;
         end
      end else begin
         rsp_valid_ff     <= 1'b0;
         spd_req_ff.start <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (accept && req_mode == MODE_SET && set_ok) begin
                  tgt_ff[set_idx] <= req_angle;
                  dur_ff[set_idx] <= req_duration;
               end
               if (accept && req_mode == MODE_FLUSH) begin
                  leg_ff      <= '0;
                  jnt_ff      <= '0;
                  idx_ff      <= '0;
                  count_ff    <= '0;
                  pend_vld_ff <= 1'b0;
                  state_ff    <= S_CHECK;
               end
            end
            S_CHECK: begin
               if (changed) begin
                  pos_ff            <= pos_clamp;
                  spd_req_ff.start  <= 1'b1;
                  spd_req_ff.scale  <= scale_ff;
                  spd_req_ff.mag    <= abs_x[MAG_W-1:0];
                  spd_req_ff.dur    <= dur_ff[idx_ff];
                  sent_ff[idx_ff]   <= cur_tgt;
                  state_ff          <= S_WAIT;
               end else if (scan_end) begin
                  state_ff <= S_FINISH;
               end else begin
                  leg_ff <= leg_in;
                  jnt_ff <= jnt_in;
                  idx_ff <= idx_ff + IDX_W'(1);
               end
            end
            S_WAIT: begin
               if (spd_rsp.done) begin
                  if (pend_vld_ff) begin
                     rsp_valid_ff     <= 1'b1;
                     rsp_has_entry_ff <= 1'b1;
                     rsp_servo_id_ff  <= pend_id_ff;
                     rsp_position_ff  <= pend_pos_ff;
                     rsp_speed_ff     <= pend_spd_ff;
                     rsp_count_ff     <= pend_cnt_ff;
                     rsp_last_ff      <= 1'b0;
                  end
                  pend_vld_ff <= 1'b1;
                  pend_id_ff  <= ID_W'({leg_ff, jnt_ff});
                  pend_pos_ff <= pos_ff;
                  pend_spd_ff <= spd_rsp.speed;
                  pend_cnt_ff <= count_ff + CNT_W'(1);
                  count_ff    <= count_ff + CNT_W'(1);
                  if (scan_end) begin
                     state_ff <= S_FINISH;
                  end else begin
                     leg_ff   <= leg_in;
                     jnt_ff   <= jnt_in;
                     idx_ff   <= idx_ff + IDX_W'(1);
                     state_ff <= S_CHECK;
                  end
               end
            end
            S_FINISH: begin
               rsp_valid_ff     <= 1'b1;
               rsp_has_entry_ff <= pend_vld_ff;
               rsp_servo_id_ff  <= pend_vld_ff ? pend_id_ff  : '0;
               rsp_position_ff  <= pend_vld_ff ? pend_pos_ff : '0;
               rsp_speed_ff     <= pend_vld_ff ? pend_spd_ff : '0;
               rsp_count_ff     <= pend_vld_ff ? pend_cnt_ff : '0;
               rsp_last_ff      <= 1'b1;
               pend_vld_ff      <= 1'b0;
               state_ff         <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy          = (state_ff != S_IDLE);
   assign csr_ready     = 1'b1;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_has_entry = rsp_has_entry_ff;
   assign rsp_servo_id  = rsp_servo_id_ff;
   assign rsp_position  = rsp_position_ff;
   assign rsp_speed     = rsp_speed_ff;
   assign rsp_count     = rsp_count_ff;
   assign rsp_last      = rsp_last_ff;

   a_last_ends_flush: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> !busy)
      else $error("flush still busy after last item");

   a_empty_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_has_entry |-> rsp_last && rsp_count == '0)
      else $error("empty flush item malformed");

   a_speed_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_has_entry |-> rsp_speed != '0 && rsp_count != '0)
      else $error("command item with zero speed or count");

   a_flush_goes_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_mode == MODE_FLUSH |=> busy)
      else $error("flush item not started");

endmodule

// File: sim/servo_target_update_batcher_chk.sv
`timescale 1ns / 100ps

module servo_target_update_batcher_chk
   import stub_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic                         busy,
   input  logic                         req_mode,
   input  logic [LEG_W-1:0]             req_leg,
   input  logic [JOINT_W-1:0]           req_joint,
   input  logic signed [ANGLE_W-1:0]    req_angle,
   input  logic [DUR_W-1:0]             req_duration,
   input  logic                         rsp_valid,
   input  logic                         rsp_has_entry,
   input  logic [ID_W-1:0]              rsp_servo_id,
   input  logic [CODE_W-1:0]            rsp_position,
   input  logic [CODE_W-1:0]            rsp_speed,
   input  logic [CNT_W-1:0]             rsp_count,
   input  logic                         rsp_last,
   input  logic                         csr_valid,
   input  logic                         csr_ready,
   input  logic [CSR_IDX_W-1:0]         csr_index,
   input  logic [CSR_DATA_W-1:0]        csr_data,
   output int                           fail_count,
   output int                           pending_count
);

   localparam int NUM_JOINTS  = NUM_LEGS_DEF * JOINTS_DEF;
   localparam int ID_STRIDE   = 4;
   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic              has_entry;
      logic [ID_W-1:0]   servo_id;
      logic [CODE_W-1:0] position;
      logic [CODE_W-1:0] speed;
      logic [CNT_W-1:0]  count;
      logic              last;
   } servo_cmd_type;

   logic signed [ANGLE_W-1:0] target_angle [NUM_JOINTS];
   logic [DUR_W-1:0]          target_dur   [NUM_JOINTS];
   logic signed [ANGLE_W-1:0] sent_angle   [NUM_JOINTS];
   logic [CODE_W-1:0]         zero_pos;
   logic [SCALE_W-1:0]        speed_scale;
   servo_cmd_type             cmd_queue [$];
   servo_cmd_type             got_cmd;
   servo_cmd_type             want_cmd;

   task automatic clear_joints();
      for (int k = 0; k < NUM_JOINTS; k++) begin
         target_angle[k] = '0;
         target_dur[k]   = '0;
         sent_angle[k]   = '0;
      end
   endtask

   // scan legs then joints, one command per changed joint, or one empty last item if none
   task automatic predict_flush();
      int            l, j, k, n, tgt, diff, mag, pos;
      longint        spd;
      servo_cmd_type cmd;
      n = 0;
      for (l = 0; l < NUM_LEGS_DEF; l++) begin
         for (j = 0; j < JOINTS_DEF; j++) begin
            k    = l * JOINTS_DEF + j;
            tgt  = target_angle[k];
            diff = int'(sent_angle[k]) - tgt;
            if (diff != 0) begin
               pos = zero_pos;
               pos = (l >= NEG_LEG_FIRST) ? pos - tgt : pos + tgt;
               if (pos < 0) begin
                  pos = 0;
               end else if (pos > int'(CODE_MAX)) begin
                  pos = CODE_MAX;
               end
               mag = (diff < 0) ? -diff : diff;
               if (target_dur[k] == 0) begin
                  spd = CODE_MAX;
               end else begin
                  spd = longint'(speed_scale) * longint'(mag) / longint'(target_dur[k]);
                  if (spd < 1) begin
                     spd = 1;
                  end else if (spd > int'(CODE_MAX)) begin
                     spd = CODE_MAX;
                  end
               end
               cmd.has_entry = 1'b1;
               cmd.servo_id  = ID_W'(l * ID_STRIDE + j);
               cmd.position  = CODE_W'(pos);
               cmd.speed     = CODE_W'(spd);
               cmd.count     = CNT_W'(n + 1);
               cmd.last      = 1'b0;
               cmd_queue.push_back(cmd);
               n++;
               sent_angle[k] = target_angle[k];
            end
         end
      end
      if (n == 0) begin
         cmd = '0;
         cmd.last = 1'b1;
         cmd_queue.push_back(cmd);
      end else begin
         cmd_queue[cmd_queue.size() - 1].last = 1'b1;
      end
   endtask

   initial begin
      fail_count    = 0;
      pending_count = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         clear_joints();
         zero_pos    = ZERO_RESET;
         speed_scale = SCALE_RESET;
         cmd_queue.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ZERO_POS:    zero_pos    = csr_data[CODE_W-1:0];
               CSR_SPEED_SCALE: speed_scale = csr_data[SCALE_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid) begin
            got_cmd = {rsp_has_entry, rsp_servo_id, rsp_position, rsp_speed, rsp_count,
                       rsp_last};
            if (cmd_queue.size() == 0) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS)
                  $display("%0t unexpected result: has_entry %0d id %0d pos %0d",
                           $time, got_cmd.has_entry, got_cmd.servo_id, got_cmd.position,
                           " spd %0d cnt %0d last %0d",
                           got_cmd.speed, got_cmd.count, got_cmd.last);
            end else begin
               want_cmd = cmd_queue.pop_front();
               if (got_cmd !== want_cmd) begin
                  fail_count++;
                  if (fail_count <= MAX_REPORTS) begin
                     $display("%0t mismatch: exp has_entry %0d id %0d pos %0d",
                              $time, want_cmd.has_entry, want_cmd.servo_id,
                              want_cmd.position, " spd %0d cnt %0d last %0d",
                              want_cmd.speed, want_cmd.count, want_cmd.last);
                     $display("%0t          got has_entry %0d id %0d pos %0d",
                              $time, got_cmd.has_entry, got_cmd.servo_id,
                              got_cmd.position, " spd %0d cnt %0d last %0d",
                              got_cmd.speed, got_cmd.count, got_cmd.last);
                  end
               end
            end
         end
         if (start && !busy) begin
            if (req_mode == MODE_SET) begin
               if (req_leg < NUM_LEGS_DEF && req_joint < JOINTS_DEF) begin
                  target_angle[req_leg * JOINTS_DEF + req_joint] = req_angle;
                  target_dur[req_leg * JOINTS_DEF + req_joint]   = req_duration;
               end
            end else begin
               predict_flush();
            end
         end
      end
      pending_count = cmd_queue.size();
   end

endmodule

// File: sim/servo_target_update_batcher_tb.sv
`timescale 1ns / 100ps

module servo_target_update_batcher_tb;
   import stub_pkg::*;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int SETTLE_CYCLES  = 40;
   localparam int ITEMS_PER_PHASE = 86;
   localparam int NUM_PHASES     = 5;
   localparam int NUM_JOINTS     = NUM_LEGS_DEF * JOINTS_DEF;
   localparam logic [CSR_IDX_W-1:0]   CSR_SPARE = 2'd3;
   localparam logic signed [ANGLE_W-1:0] ANGLE_MIN = 11'h400;
   localparam logic signed [ANGLE_W-1:0] ANGLE_MAX = 11'h3FF;
   localparam logic [DUR_W-1:0]       DUR_MAX   = 15'h7FFF;

   logic                      clock;
   logic                      reset;
   logic                      start;
   logic                      busy;
   logic                      req_mode;
   logic [LEG_W-1:0]          req_leg;
   logic [JOINT_W-1:0]        req_joint;
   logic signed [ANGLE_W-1:0] req_angle;
   logic [DUR_W-1:0]          req_duration;
   logic                      rsp_valid;
   logic                      rsp_has_entry;
   logic [ID_W-1:0]           rsp_servo_id;
   logic [CODE_W-1:0]         rsp_position;
   logic [CODE_W-1:0]         rsp_speed;
   logic [CNT_W-1:0]          rsp_count;
   logic                      rsp_last;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [CSR_IDX_W-1:0]      csr_index;
   logic [CSR_DATA_W-1:0]     csr_data;

   int fail_count;
   int pending_count;
   int idle_cycles;
   int items_done;
   int burst_left;
   int gap_max;

   servo_target_update_batcher dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_mode      (req_mode),
      .req_leg       (req_leg),
      .req_joint     (req_joint),
      .req_angle     (req_angle),
      .req_duration  (req_duration),
      .rsp_valid     (rsp_valid),
      .rsp_has_entry (rsp_has_entry),
      .rsp_servo_id  (rsp_servo_id),
      .rsp_position  (rsp_position),
      .rsp_speed     (rsp_speed),
      .rsp_count     (rsp_count),
      .rsp_last      (rsp_last),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   servo_target_update_batcher_chk chk (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_mode      (req_mode),
      .req_leg       (req_leg),
      .req_joint     (req_joint),
      .req_angle     (req_angle),
      .req_duration  (req_duration),
      .rsp_valid     (rsp_valid),
      .rsp_has_entry (rsp_has_entry),
      .rsp_servo_id  (rsp_servo_id),
      .rsp_position  (rsp_position),
      .rsp_speed     (rsp_speed),
      .rsp_count     (rsp_count),
      .rsp_last      (rsp_last),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic pace();
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         repeat ($urandom_range(gap_max, 0)) @(negedge clock);
         burst_left = $urandom_range(1, 12);
      end
   endtask

   task automatic send_item(input logic mode, input logic [LEG_W-1:0] leg,
                            input logic [JOINT_W-1:0] joint,
                            input logic signed [ANGLE_W-1:0] angle,
                            input logic [DUR_W-1:0] dur);
      req_mode     = mode;
      req_leg      = leg;
      req_joint    = joint;
      req_angle    = angle;
      req_duration = dur;
      start        = 1'b1;
      do @(posedge clock); while (busy);
      @(negedge clock);
      start = 1'b0;
      pace();
   endtask

   task automatic send_flush();
      send_item(MODE_FLUSH, LEG_W'($urandom), JOINT_W'($urandom), ANGLE_W'($urandom),
                DUR_W'($urandom));
   endtask

   task automatic wait_idle();
      start = 1'b0;
      while (pending_count != 0 || busy) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_index = idx;
      csr_data  = data;
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic logic signed [ANGLE_W-1:0] rand_angle();
      logic signed [ANGLE_W-1:0] a;
      case ($urandom_range(0, 5))
         0: a = ANGLE_MIN;
         1: a = ANGLE_MAX;
         2: a = ANGLE_W'(int'($urandom_range(0, 6)) - 3);
         default: a = ANGLE_W'($urandom);
      endcase
      return a;
   endfunction

   function automatic logic [DUR_W-1:0] rand_dur();
      logic [DUR_W-1:0] d;
      case ($urandom_range(0, 5))
         0: d = '0;
         1: d = DUR_W'($urandom_range(1, 30));
         2: d = DUR_MAX;
         default: d = DUR_W'($urandom);
      endcase
      return d;
   endfunction

   // a run of joint updates followed by one or sometimes two flushes
   task automatic run_batch();
      int               n_sets;
      bit               sweep;
      logic [LEG_W-1:0] leg;
      logic [JOINT_W-1:0] joint;
      sweep = 1'b0;
      case ($urandom_range(0, 9))
         0: n_sets = 0;
         1: begin
            n_sets = NUM_JOINTS;
            sweep  = 1'b1;
         end
         default: n_sets = $urandom_range(1, 8);
      endcase
      for (int i = 0; i < n_sets; i++) begin
         if ($urandom_range(0, 9) == 0) begin
            leg   = LEG_W'($urandom);
            joint = JOINT_W'($urandom);
         end else if (sweep) begin
            leg   = LEG_W'(i / JOINTS_DEF);
            joint = JOINT_W'(i % JOINTS_DEF);
         end else begin
            leg   = LEG_W'($urandom_range(0, NUM_LEGS_DEF - 1));
            joint = JOINT_W'($urandom_range(0, JOINTS_DEF - 1));
         end
         send_item(MODE_SET, leg, joint, rand_angle(), rand_dur());
         if (leg < NUM_LEGS_DEF && joint < JOINTS_DEF) items_done++;
      end
      if ($urandom_range(0, 7) == 0) wait_idle();
      send_flush();
      items_done++;
      if ($urandom_range(0, 9) == 0) begin
         send_flush();
         items_done++;
      end
   endtask

   initial begin
      logic [CODE_W-1:0]  zero_v;
      logic [SCALE_W-1:0] scale_v;
      reset        = 1'b1;
      start        = 1'b0;
      req_mode     = MODE_SET;
      req_leg      = '0;
      req_joint    = '0;
      req_angle    = '0;
      req_duration = '0;
      csr_valid    = 1'b0;
      csr_index    = CSR_ZERO_POS;
      csr_data     = '0;
      idle_cycles  = 0;
      items_done   = 0;
      burst_left   = 0;
      gap_max      = 4;
      repeat (2) @(negedge clock);
      reset = 1'b0;

      // directed part on reset settings
      send_flush();
      send_item(MODE_SET, 3'd0, 2'd0, ANGLE_MAX, 15'd1);
      send_item(MODE_SET, 3'd5, 2'd2, ANGLE_MIN, DUR_MAX);
      send_item(MODE_SET, 3'd3, 2'd1, 11'sd100, 15'd0);
      send_item(MODE_SET, 3'd1, 2'd2, ANGLE_MIN, 15'd3);
      send_item(MODE_SET, 3'd6, 2'd0, 11'sd5, 15'd2);
      send_item(MODE_SET, 3'd7, 2'd3, ANGLE_MAX, DUR_MAX);
      send_item(MODE_SET, 3'd2, 2'd3, 11'sd7, 15'd1);
      send_item(MODE_SET, 3'd4, 2'd0, -11'sd1, 15'd5);
      send_flush();
      send_flush();
      send_item(MODE_SET, 3'd0, 2'd0, ANGLE_MAX, DUR_MAX);
      send_item(MODE_SET, 3'd2, 2'd1, ANGLE_MAX, 15'd1);
      send_flush();
      send_item(MODE_SET, 3'd0, 2'd0, 11'sd0, 15'd7);
      send_flush();

      for (int p = 0; p < NUM_PHASES; p++) begin
         wait_idle();
         case (p)
            0: begin
               zero_v  = '0;
               scale_v = 16'hFFFF;
            end
            1: begin
               zero_v  = CODE_MAX;
               scale_v = '0;
            end
            2: begin
               zero_v  = ZERO_RESET;
               scale_v = SCALE_RESET;
            end
            3: begin
               zero_v  = CODE_W'($urandom);
               scale_v = SCALE_W'($urandom);
            end
            default: begin
               zero_v  = CODE_W'($urandom_range(0, 1023));
               scale_v = SCALE_W'($urandom_range(1, 2000));
            end
         endcase
         if (p == 0) write_csr(CSR_SPARE, CSR_DATA_W'($urandom));
         write_csr(CSR_ZERO_POS, {6'($urandom), zero_v});
         write_csr(CSR_SPEED_SCALE, scale_v);
         gap_max = (p == 2) ? 0 : 15;
         while (items_done < (p + 1) * ITEMS_PER_PHASE) run_batch();
      end

      wait_idle();
      if (fail_count == 0 && pending_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
